// ----- src/srdc_pkg.sv -----
`timescale 1ns / 1ps

package srdc_pkg;

  // Default build values
  localparam int NUM_WHEELS_DEF  = 4;
  localparam int SENSE_WIDTH_DEF = 10;

  // Field widths of the transfer payloads
  localparam int DIGIT_W    = 4;
  localparam int SENSE_W    = 10;
  localparam int POS_W      = 8;
  localparam int OUT_WHEELS = 4;
  localparam int SIZE_W     = 2;
  localparam int TICK_W     = 5;
  localparam int PULSE_W    = 5;

  // Position codes
  localparam logic [POS_W-1:0] POS_UNKNOWN = 8'd254;
  localparam logic [POS_W-1:0] POS_BROKEN  = 8'd255;
  localparam logic [POS_W-1:0] POS_LAST    = 8'd9;

  localparam logic [PULSE_W-1:0] MAX_PULSES = 5'd20;
  localparam int RISE_LIMIT = 50;

  localparam logic [SIZE_W-1:0] REEL_SIZE_RST = 2'd3;

  // Coil timing in 10 ms ticks, rounded up
  localparam int TICK_MS   = 10;
  localparam int PULSE_MS  = 30;
  localparam int PAUSE_MS0 = 100;
  localparam int PAUSE_MS1 = 125;
  localparam int PAUSE_MS2 = 150;
  localparam int PAUSE_MS3 = 175;
  localparam logic [TICK_W-1:0] PULSE_TICKS  = TICK_W'((PULSE_MS + TICK_MS - 1) / TICK_MS);
  localparam logic [TICK_W-1:0] PAUSE_TICKS0 = TICK_W'((PAUSE_MS0 + TICK_MS - 1) / TICK_MS);
  localparam logic [TICK_W-1:0] PAUSE_TICKS1 = TICK_W'((PAUSE_MS1 + TICK_MS - 1) / TICK_MS);
  localparam logic [TICK_W-1:0] PAUSE_TICKS2 = TICK_W'((PAUSE_MS2 + TICK_MS - 1) / TICK_MS);
  localparam logic [TICK_W-1:0] PAUSE_TICKS3 = TICK_W'((PAUSE_MS3 + TICK_MS - 1) / TICK_MS);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE           = 4'd0;
  localparam logic [3:0] ST_HOME_START     = 4'd1;
  localparam logic [3:0] ST_HOME_HIGH      = 4'd2;
  localparam logic [3:0] ST_HOME_HIGH_WAIT = 4'd3;
  localparam logic [3:0] ST_HOME_LOW       = 4'd4;
  localparam logic [3:0] ST_HOME_LOW_WAIT  = 4'd5;
  localparam logic [3:0] ST_HOME_CHECK     = 4'd6;
  localparam logic [3:0] ST_STEP_START     = 4'd7;
  localparam logic [3:0] ST_STEP_HIGH_WAIT = 4'd8;
  localparam logic [3:0] ST_STEP_LOW       = 4'd9;
  localparam logic [3:0] ST_STEP_LOW_WAIT  = 4'd10;

  typedef struct packed {
    logic [DIGIT_W-1:0]    target_min;
    logic [DIGIT_W-1:0]    target_tenmin;
    logic [DIGIT_W-1:0]    target_hour;
    logic [DIGIT_W-1:0]    target_tenhour;
    logic [OUT_WHEELS-1:0] zero_request;
    logic                  rehome_all;
    logic [SENSE_W-1:0]    sense_level;
  } srdc_in_t;

  typedef struct packed {
    logic [OUT_WHEELS-1:0] coil_drive;
    logic                  fault_lamp;
    logic                  busy_res;
    logic [POS_W-1:0]      pos_min;
    logic [POS_W-1:0]      pos_tenmin;
    logic [POS_W-1:0]      pos_hour;
    logic [POS_W-1:0]      pos_tenhour;
  } srdc_out_t;

  function automatic logic [TICK_W-1:0] pause_ticks(input logic [SIZE_W-1:0] size);
    logic [TICK_W-1:0] t;
    unique case (size)
      2'd0:    t = PAUSE_TICKS0;
      2'd1:    t = PAUSE_TICKS1;
      2'd2:    t = PAUSE_TICKS2;
      default: t = PAUSE_TICKS3;
    endcase
    return t;
  endfunction

endpackage

// ----- src/score_reel_drive_controller.sv -----
`timescale 1ns / 1ps

// Score reel drive controller: sequences the coils of NUM_WHEELS decimal
// score reels, homing unknown wheels against the home sensor and stepping
// known wheels toward their target digits.
// Input channel (in_valid/in_ready/in_data): one transfer per 10 ms tick with
// the target digits, homing requests, re-home command and one sensor sample.
// Result channel (out_valid/out_ready/out_data): one transfer per tick with
// the coil levels, fault lamp, busy flag and all wheel positions after it.
// Config port: cfg_we/cfg_wdata write the reel size (pause 10/13/15/18 ticks).
// Path: an accepted tick lands in the input register, is processed from
// there, and its result is captured in the result register once that
// slot is free or draining.
// Throughput: one tick per cycle unless the receiver stalls; the whole
// sequencer step is one pass of logic from input register to result register.
// Receiver stall: the result register holds; the input register takes one
// more tick, then in_ready drops until the result is taken.
// Reset (rst_n low, synchronous): sequencer idle, all positions unknown,
// all coils off, reel size 3 (largest pause), both channels empty.
module score_reel_drive_controller
  import srdc_pkg::*;
#(
  parameter int NUM_WHEELS  = srdc_pkg::NUM_WHEELS_DEF,
  parameter int SENSE_WIDTH = srdc_pkg::SENSE_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  srdc_pkg::srdc_in_t        in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output srdc_pkg::srdc_out_t       out_data,
  input  logic                      cfg_we,
  input  logic [srdc_pkg::SIZE_W-1:0] cfg_wdata
);

  // Sensor bits kept: the sample field masked down to SENSE_WIDTH
  localparam int SenseBits = (SENSE_WIDTH < SENSE_W) ? SENSE_WIDTH : SENSE_W;
  // Wheels that map onto the fixed payload fields
  localparam int NShown    = (NUM_WHEELS < OUT_WHEELS) ? NUM_WHEELS : OUT_WHEELS;
  localparam int WheelIdxW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  // Handshake registers
  logic      in_valid_r;
  srdc_in_t  in_data_r;
  logic      out_valid_r;
  srdc_out_t out_data_r, out_data_nxt;
  logic      advance;

  // Sequencer state
  logic [SIZE_W-1:0]    reel_size_r;
  logic [3:0]           seq_state_r, seq_state_nxt;
  logic [WheelIdxW-1:0] active_wheel_r, active_wheel_nxt;
  logic [PULSE_W-1:0]   pulse_count_r, pulse_count_nxt;
  logic [TICK_W-1:0]    tick_delay_r, tick_delay_nxt;
  logic [SenseBits-1:0] prev_sense_r, prev_sense_nxt;
  logic [POS_W-1:0]     wheel_pos_r [NUM_WHEELS];
  logic [POS_W-1:0]     wheel_pos_nxt [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] home_pending_r, home_pending_nxt;
  logic [NUM_WHEELS-1:0] coil_level_r, coil_level_nxt;
  logic                 moving_r, moving_nxt;

  // Working values for one tick
  logic [DIGIT_W-1:0]   target [NUM_WHEELS];
  logic [SenseBits-1:0] sense;
  logic                 rise;
  logic [PULSE_W-1:0]   pulse_inc;
  logic                 found_home, found_step;
  logic [WheelIdxW-1:0] home_sel, step_sel;
  logic                 fault;
  logic [POS_W-1:0]     pos_shown [OUT_WHEELS];

  // A tick moves to the result register when the result slot is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sense     = in_data_r.sense_level[SenseBits-1:0];
  // Rise only when the sample exceeds the previous one by more than the limit
  assign rise      = {1'b0, sense} > ({1'b0, prev_sense_r} + (SenseBits + 1)'(RISE_LIMIT));
  assign pulse_inc = pulse_count_r + PULSE_W'(1);

  always_comb begin
    // Targets and requests of wheels beyond the payload stay zero
    for (int i = 0; i < NUM_WHEELS; i++) begin
      target[i] = '0;
    end
    if (NShown > 0) target[0] = in_data_r.target_min;
    if (NShown > 1) target[1] = in_data_r.target_tenmin;
    if (NShown > 2) target[2] = in_data_r.target_hour;
    if (NShown > 3) target[3] = in_data_r.target_tenhour;

    home_pending_nxt = home_pending_r;
    for (int i = 0; i < NShown; i++) begin
      if (in_data_r.zero_request[i]) home_pending_nxt[i] = 1'b1;
    end

    // Re-home forgets every position, broken marks included
    for (int i = 0; i < NUM_WHEELS; i++) begin
      wheel_pos_nxt[i] = in_data_r.rehome_all ? POS_UNKNOWN : wheel_pos_r[i];
    end

    // Idle scan: homing first, then stepping, lowest wheel wins
    found_home = 1'b0;
    home_sel   = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (!found_home && wheel_pos_nxt[i] != POS_BROKEN &&
          (home_pending_nxt[i] || wheel_pos_nxt[i] == POS_UNKNOWN)) begin
        found_home = 1'b1;
        home_sel   = WheelIdxW'(i);
      end
    end
    found_step = 1'b0;
    step_sel   = '0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (!found_step && wheel_pos_nxt[i] < POS_UNKNOWN &&
          wheel_pos_nxt[i] != {{(POS_W - DIGIT_W){1'b0}}, target[i]}) begin
        found_step = 1'b1;
        step_sel   = WheelIdxW'(i);
      end
    end

    seq_state_nxt    = seq_state_r;
    active_wheel_nxt = active_wheel_r;
    pulse_count_nxt  = pulse_count_r;
    tick_delay_nxt   = tick_delay_r;
    prev_sense_nxt   = prev_sense_r;
    coil_level_nxt   = coil_level_r;
    moving_nxt       = moving_r;

    unique case (seq_state_r)
      ST_IDLE: begin
        if (found_home) begin
          active_wheel_nxt = home_sel;
          seq_state_nxt    = ST_HOME_START;
          moving_nxt       = 1'b1;
        end else if (found_step) begin
          active_wheel_nxt = step_sel;
          seq_state_nxt    = ST_STEP_START;
          moving_nxt       = 1'b1;
        end else begin
          moving_nxt = 1'b0;
        end
      end
      ST_HOME_START: begin
        prev_sense_nxt  = sense;
        pulse_count_nxt = '0;
        seq_state_nxt   = ST_HOME_HIGH;
      end
      ST_HOME_HIGH, ST_STEP_START: begin
        tick_delay_nxt = PULSE_TICKS;
        coil_level_nxt = coil_level_r | (NUM_WHEELS'(1) << active_wheel_r);
        seq_state_nxt  = (seq_state_r == ST_HOME_HIGH) ? ST_HOME_HIGH_WAIT
                                                       : ST_STEP_HIGH_WAIT;
      end
      ST_HOME_HIGH_WAIT, ST_STEP_HIGH_WAIT: begin
        if (tick_delay_r != '0) begin
          tick_delay_nxt = tick_delay_r - TICK_W'(1);
        end else begin
          seq_state_nxt = (seq_state_r == ST_HOME_HIGH_WAIT) ? ST_HOME_LOW : ST_STEP_LOW;
        end
      end
      ST_HOME_LOW, ST_STEP_LOW: begin
        tick_delay_nxt = pause_ticks(reel_size_r);
        coil_level_nxt = coil_level_r & ~(NUM_WHEELS'(1) << active_wheel_r);
        seq_state_nxt  = (seq_state_r == ST_HOME_LOW) ? ST_HOME_LOW_WAIT : ST_STEP_LOW_WAIT;
      end
      ST_HOME_LOW_WAIT: begin
        if (tick_delay_r != '0) begin
          tick_delay_nxt = tick_delay_r - TICK_W'(1);
        end else begin
          seq_state_nxt = ST_HOME_CHECK;
        end
      end
      ST_HOME_CHECK: begin
        pulse_count_nxt = pulse_inc;
        if (pulse_inc < MAX_PULSES && !rise) begin
          prev_sense_nxt = sense;
          seq_state_nxt  = ST_HOME_HIGH;
        end else begin
          // The last pulse marks the wheel broken even on a rise
          if (pulse_inc >= MAX_PULSES) begin
            wheel_pos_nxt[active_wheel_r] = POS_BROKEN;
          end else begin
            home_pending_nxt[active_wheel_r] = 1'b0;
            wheel_pos_nxt[active_wheel_r]    = '0;
          end
          seq_state_nxt = ST_IDLE;
        end
      end
      ST_STEP_LOW_WAIT: begin
        if (tick_delay_r != '0) begin
          tick_delay_nxt = tick_delay_r - TICK_W'(1);
        end else begin
          // Advance the digit; a wheel re-homed meanwhile stays unknown
          if (wheel_pos_nxt[active_wheel_r] >= POS_LAST) begin
            if (wheel_pos_nxt[active_wheel_r] < POS_UNKNOWN) begin
              wheel_pos_nxt[active_wheel_r] = '0;
            end
          end else begin
            wheel_pos_nxt[active_wheel_r] = wheel_pos_nxt[active_wheel_r] + POS_W'(1);
          end
          seq_state_nxt = ST_IDLE;
        end
      end
      default: begin
        seq_state_nxt = ST_IDLE;
      end
    endcase

    // Result: state after the tick
    fault = 1'b0;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (wheel_pos_nxt[i] == POS_BROKEN) fault = 1'b1;
    end
    for (int i = 0; i < OUT_WHEELS; i++) begin
      pos_shown[i] = '0;
    end
    out_data_nxt            = '0;
    for (int i = 0; i < NShown; i++) begin
      pos_shown[i]                = wheel_pos_nxt[i];
      out_data_nxt.coil_drive[i]  = coil_level_nxt[i];
    end
    out_data_nxt.fault_lamp  = fault;
    out_data_nxt.busy_res    = moving_nxt;
    out_data_nxt.pos_min     = pos_shown[0];
    out_data_nxt.pos_tenmin  = pos_shown[1];
    out_data_nxt.pos_hour    = pos_shown[2];
    out_data_nxt.pos_tenhour = pos_shown[3];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      reel_size_r    <= REEL_SIZE_RST;
      seq_state_r    <= ST_IDLE;
      active_wheel_r <= '0;
      pulse_count_r  <= '0;
      tick_delay_r   <= '0;
      prev_sense_r   <= '0;
      home_pending_r <= '0;
      coil_level_r   <= '0;
      moving_r       <= 1'b0;
      for (int i = 0; i < NUM_WHEELS; i++) begin
        wheel_pos_r[i] <= POS_UNKNOWN;
      end
    end else begin
      if (cfg_we) reel_size_r <= cfg_wdata;
      if (in_ready) in_valid_r <= in_valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // Commit the tick only when its result is captured
      if (advance) begin
        seq_state_r    <= seq_state_nxt;
        active_wheel_r <= active_wheel_nxt;
        pulse_count_r  <= pulse_count_nxt;
        tick_delay_r   <= tick_delay_nxt;
        prev_sense_r   <= prev_sense_nxt;
        home_pending_r <= home_pending_nxt;
        coil_level_r   <= coil_level_nxt;
        moving_r       <= moving_nxt;
        for (int i = 0; i < NUM_WHEELS; i++) begin
          wheel_pos_r[i] <= wheel_pos_nxt[i];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_data_r <= in_data;
    if (advance) out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // Only the selected wheel's coil may ever be energized
  a_coil_active_only: assert property (@(posedge clk) disable iff (!rst_n)
    coil_level_r == '0 || coil_level_r == (NUM_WHEELS'(1) << active_wheel_r))
    else $error("coil energized on a wheel other than the active one");

  // The sequencer never rests in idle with a coil still on
  a_idle_coils_off: assert property (@(posedge clk) disable iff (!rst_n)
    seq_state_r == ST_IDLE |-> coil_level_r == '0)
    else $error("coil left energized in idle");

  // Delay never exceeds the longest pause
  a_delay_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tick_delay_r <= PAUSE_TICKS3)
    else $error("tick delay out of range");

  // Homing stops at the pulse limit
  a_pulse_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_count_r <= MAX_PULSES)
    else $error("pulse count beyond limit");

  // State moves only when a tick is committed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(seq_state_r) && $stable(coil_level_r))
    else $error("sequencer moved without a tick");
`endif

endmodule
